>>> hw/rtl/bc_pkg.sv
// Shared types and constants for the binomial coefficient block.
// No dependencies; imported by bc_div, bc_mul and binomial_coefficient.
package bc_pkg;

	localparam int ACC_WIDTH     = 64;
	localparam int HALF_WIDTH    = ACC_WIDTH / 2;
	localparam int ARG_WIDTH_DEF = 16;
	localparam int CNT_WIDTH     = $clog2(ACC_WIDTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DTOP,
		ST_DACC,
		ST_MUL1,
		ST_MUL2,
		ST_DPROD,
		ST_DONE
	} bc_state_t;

	// divider launch: short_arg means the dividend is only ARG_WIDTH bits wide
	typedef struct packed {
		logic start;
		logic short_arg;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

>>> hw/rtl/bc_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by narrow divisor.
// Depends on bc_pkg.
module bc_div import bc_pkg::*; #(
	parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	input  logic [ACC_WIDTH-1:0] dividend,
	input  logic [ARG_WIDTH-1:0] divisor,
	output unit_sts_t            sts,
	output logic [ACC_WIDTH-1:0] quotient,
	output logic [ARG_WIDTH-1:0] remainder
);

	logic [ACC_WIDTH-1:0] dvd_q;
	logic [ARG_WIDTH-1:0] rem_q;
	logic [ARG_WIDTH-1:0] dsr_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [ARG_WIDTH:0]   rem_shift;
	logic                 ge;
	logic [ARG_WIDTH:0]   rem_next;

	assign rem_shift = {rem_q, dvd_q[ACC_WIDTH-1]};
	assign ge        = rem_shift >= {1'b0, dsr_q};
	assign rem_next  = ge ? (rem_shift - {1'b0, dsr_q}) : rem_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.short_arg ? CNT_WIDTH'(ARG_WIDTH) : CNT_WIDTH'(ACC_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.short_arg
				? (ACC_WIDTH'(dividend[ARG_WIDTH-1:0]) << (ACC_WIDTH - ARG_WIDTH))
				: dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ACC_WIDTH-2:0], ge};
			rem_q <= rem_next[ARG_WIDTH-1:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

>>> hw/rtl/bc_mul.sv
// 64 x ARG_WIDTH multiplier, low half then high half, product modulo 2^64, one shared 32x32 array.
// Depends on bc_pkg.
module bc_mul import bc_pkg::*; #(
	parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ACC_WIDTH-1:0] mcand,
	input  logic [ARG_WIDTH-1:0] mplier,
	output unit_sts_t            sts,
	output logic [ACC_WIDTH-1:0] product
);

	logic [ACC_WIDTH-1:0]  a_q;
	logic [HALF_WIDTH-1:0] f_q;
	logic [ACC_WIDTH-1:0]  plo_q;
	logic [ACC_WIDTH-1:0]  prod_q;
	logic                  hi_phase_q;
	logic                  busy_q;
	logic                  done_q;

	logic [HALF_WIDTH-1:0] op_a;
	logic [ACC_WIDTH-1:0]  pp;

	assign op_a = hi_phase_q ? a_q[ACC_WIDTH-1:HALF_WIDTH] : a_q[HALF_WIDTH-1:0];
	assign pp   = ACC_WIDTH'(op_a) * ACC_WIDTH'(f_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			hi_phase_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q     <= 1'b1;
				hi_phase_q <= 1'b0;
			end else if (busy_q) begin
				hi_phase_q <= 1'b1;
				if (hi_phase_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= mcand;
			f_q <= HALF_WIDTH'(mplier);
		end else if (busy_q) begin
			if (!hi_phase_q) begin
				plo_q <= pp;
			end else begin
				// high half only feeds bits 63:32 of the wrapped product
				prod_q <= plo_q + {pp[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = prod_q;

endmodule

>>> hw/rtl/binomial_coefficient.sv
// Binomial coefficient C(n,k), 64-bit result modulo 2^64, multiplicative method.
// Depends on bc_pkg, bc_div and bc_mul.
//
// One beat in gives one beat out. The block takes min(k, n-k) steps per item;
// step j (from 1) with factor top (from n, falling) uses a shared restoring
// divider (one quotient bit per cycle) and a shared multiplier. A step in
// which j divides top costs a short divide of top and a multiply; one in which
// j divides the running value adds a 64-bit divide of it; otherwise the step
// ends with a multiply and a 64-bit divide of the product. An item's time is
// the sum over its steps, dominated by the divider's bit-serial loop. When
// k > n no step runs: coefficient is 0 and invalid is 1. k = 0 or k = n gives 1.
// in_ready is high only while the sequencer is idle; the output register lets
// the next beat in while a finished result still waits for out_ready.
module binomial_coefficient import bc_pkg::*; #(
	parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ARG_WIDTH-1:0] n_total,
	input  logic [ARG_WIDTH-1:0] k_chosen,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ACC_WIDTH-1:0] coefficient,
	output logic                 invalid
);

	bc_state_t state_q, state_d;

	logic [ACC_WIDTH-1:0] acc_q;
	logic [ARG_WIDTH-1:0] top_q;
	logic [ARG_WIDTH-1:0] j_q;
	logic [ARG_WIDTH-1:0] steps_q;
	logic                 inv_q;
	logic                 out_valid_q;
	logic [ACC_WIDTH-1:0] out_coef_q;
	logic                 out_inv_q;

	// unit hookup
	div_req_t             div_req;
	logic [ACC_WIDTH-1:0] div_dvd;
	unit_sts_t            div_sts;
	logic [ACC_WIDTH-1:0] div_quot;
	logic [ARG_WIDTH-1:0] div_rem;
	logic                 mul_start;
	logic [ACC_WIDTH-1:0] mul_a;
	logic [ARG_WIDTH-1:0] mul_f;
	unit_sts_t            mul_sts;
	logic [ACC_WIDTH-1:0] mul_prod;

	// sequencer controls
	logic                 accept;
	logic                 acc_ld;
	logic                 acc_from_div;
	logic                 step_adv;
	logic                 out_ld;
	logic                 k_gt_n;
	logic [ARG_WIDTH-1:0] n_minus_k;
	logic [ARG_WIDTH-1:0] steps_in;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign k_gt_n    = k_chosen > n_total;
	assign n_minus_k = n_total - k_chosen;
	assign steps_in  = (k_chosen > n_minus_k) ? n_minus_k : k_chosen;

	bc_div #(.ARG_WIDTH(ARG_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dvd),
		.divisor   (j_q),
		.sts       (div_sts),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	bc_mul #(.ARG_WIDTH(ARG_WIDTH)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_a),
		.mplier  (mul_f),
		.sts     (mul_sts),
		.product (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step order: top/j first; if exact, acc*(top/j). Else acc/j; if exact,
	// (acc/j)*top. Else (acc*top)/j with the wrapped product.
	always_comb begin
		state_d           = state_q;
		div_req.start     = 1'b0;
		div_req.short_arg = 1'b0;
		div_dvd           = acc_q;
		mul_start         = 1'b0;
		mul_a             = acc_q;
		mul_f             = top_q;
		acc_ld            = 1'b0;
		acc_from_div      = 1'b0;
		step_adv          = 1'b0;
		out_ld            = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = k_gt_n ? ST_DONE : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (j_q > steps_q) begin
					state_d = ST_DONE;
				end else begin
					div_req.start     = 1'b1;
					div_req.short_arg = 1'b1;
					div_dvd           = ACC_WIDTH'(top_q);
					state_d           = ST_DTOP;
				end
			end
			ST_DTOP: begin
				if (div_sts.done) begin
					if (div_rem == '0) begin
						mul_start = 1'b1;
						mul_f     = div_quot[ARG_WIDTH-1:0];
						state_d   = ST_MUL1;
					end else begin
						div_req.start = 1'b1;
						state_d       = ST_DACC;
					end
				end
			end
			ST_DACC: begin
				if (div_sts.done) begin
					mul_start = 1'b1;
					if (div_rem == '0) begin
						mul_a   = div_quot;
						state_d = ST_MUL1;
					end else begin
						state_d = ST_MUL2;
					end
				end
			end
			ST_MUL1: begin
				if (mul_sts.done) begin
					acc_ld   = 1'b1;
					step_adv = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_MUL2: begin
				if (mul_sts.done) begin
					div_req.start = 1'b1;
					div_dvd       = mul_prod;
					state_d       = ST_DPROD;
				end
			end
			ST_DPROD: begin
				if (div_sts.done) begin
					acc_ld       = 1'b1;
					acc_from_div = 1'b1;
					step_adv     = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_DONE: begin
				// output register free or emptying this cycle
				if (!out_valid_q || out_ready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q   <= k_gt_n ? '0 : ACC_WIDTH'(1);
			inv_q   <= k_gt_n;
			top_q   <= n_total;
			j_q     <= ARG_WIDTH'(1);
			steps_q <= steps_in;
		end else begin
			if (acc_ld) begin
				acc_q <= acc_from_div ? div_quot : mul_prod;
			end
			if (step_adv) begin
				top_q <= top_q - 1'b1;
				j_q   <= j_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_coef_q <= acc_q;
			out_inv_q  <= inv_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign coefficient = out_coef_q;
	assign invalid     = out_inv_q;

	// a unit is never relaunched while it still iterates
	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_mul_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	// divider results only show up where the sequencer waits for them
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DTOP || state_q == ST_DACC || state_q == ST_DPROD))
		else $error("divider done outside a divide wait state");

	// the step index never reaches zero, so no division by zero
	a_j_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DTOP || state_q == ST_DACC || state_q == ST_DPROD) |-> j_q != '0)
		else $error("step index is zero during a divide");

	// a result loaded into the output register enters a beat on the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |=> out_valid_q && (out_inv_q == $past(inv_q)))
		else $error("output register did not take the finished result");

endmodule
